### rtl/core/dfpd_pkg.sv
// Shared types, constants and helpers for the DLE-framed packet deframer.
package dfpd_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int MIN_FRAME_BYTES = 5;
    localparam int TYPE_LIMIT      = 7;
    localparam int HEADER_BYTES    = 2;

    // Command queue between the front and back halves.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_HEAD_DLE   = 3'd0;
    localparam logic [2:0] REG_HEAD_SOM   = 3'd1;
    localparam logic [2:0] REG_TAIL_DLE   = 3'd2;
    localparam logic [2:0] REG_TAIL_EOF   = 3'd3;
    localparam logic [2:0] REG_LONG_LEN   = 3'd4;
    localparam logic [2:0] REG_SHORT_LEN  = 3'd5;
    localparam logic [2:0] REG_TIMEOUT    = 3'd6;

    // Frame status codes.
    localparam logic [2:0] ST_OPEN     = 3'd0;
    localparam logic [2:0] ST_GOOD     = 3'd1;
    localparam logic [2:0] ST_BAD_TAIL = 3'd2;
    localparam logic [2:0] ST_TYPE_ERR = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic [7:0] byte_index;
        logic [2:0] frame_status;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [7:0] head_dle_value;
        logic [7:0] head_som_value;
        logic [7:0] tail_dle_value;
        logic [7:0] tail_eof_value;
        logic [8:0] long_frame_len;
        logic [8:0] short_frame_len;
        logic [7:0] timeout_ticks;
    } t_cfg;

    // One command per input item that gives any result. A header command
    // expands into two results in the back half.
    typedef struct packed {
        logic       hdr;
        logic       out_valid;
        logic [7:0] out_byte;
        logic [7:0] byte_index;
        logic [2:0] frame_status;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
        t_cmd head;
    } t_q_status;

    function automatic logic [8:0] clamp_len(input logic [8:0] len);
        logic [8:0] res;
        if (len < 9'(MIN_FRAME_BYTES)) begin
            res = 9'(MIN_FRAME_BYTES);
        end else if (len > 9'(MAX_FRAME_BYTES)) begin
            res = 9'(MAX_FRAME_BYTES);
        end else begin
            res = len;
        end
        return res;
    endfunction

endpackage

### rtl/core/dfpd_front.sv
// Front half: accepts bytes and ticks, tracks the frame and issues commands.
module dfpd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dfpd_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    input  dfpd_pkg::t_in_item i_in_item,
    input  logic               i_q_full,
    output dfpd_pkg::t_push    o_push
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SOM,
        PH_TYPE,
        PH_BODY
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [8:0] r_len, n_len;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_tc, n_tc;
    logic       r_tail, n_tail;

    logic       accept;
    logic [7:0] b;
    logic [7:0] tc_inc;
    logic       tail_n;
    logic       good;
    logic [8:0] pos9;

    assign accept = i_in_valid & ~i_q_full;
    assign b      = i_in_item.rx_byte;
    assign pos9   = {1'b0, r_pos};
    assign tc_inc = (r_tc == 8'hFF) ? r_tc : r_tc + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_pos   = r_pos;
        n_tc    = r_tc;
        n_tail  = r_tail;
        o_push  = '0;
        tail_n  = r_tail;
        good    = 1'b0;
        if (accept) begin
            if (i_in_item.req_type) begin
                if (r_phase == PH_TYPE || r_phase == PH_BODY) begin
                    if (tc_inc >= i_cfg.timeout_ticks) begin
                        n_phase = PH_HUNT;
                        n_len   = '0;
                        n_pos   = '0;
                        n_tc    = '0;
                        n_tail  = 1'b0;
                        o_push.push = 1'b1;
                        o_push.cmd.frame_status = dfpd_pkg::ST_TIMEOUT;
                    end else begin
                        n_tc = tc_inc;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_HUNT: begin
                        if (b == i_cfg.head_dle_value) begin
                            n_phase = PH_SOM;
                        end
                    end
                    PH_SOM: begin
                        if (b == i_cfg.head_som_value) begin
                            n_phase = PH_TYPE;
                            n_tc    = '0;
                            o_push.push          = 1'b1;
                            o_push.cmd.hdr       = 1'b1;
                            o_push.cmd.out_valid = 1'b1;
                            o_push.cmd.out_byte  = b;
                        end else begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_TYPE: begin
                        o_push.push = 1'b1;
                        if (b != 8'd0 && b < 8'(dfpd_pkg::TYPE_LIMIT)) begin
                            n_len   = dfpd_pkg::clamp_len(b[0] ? i_cfg.long_frame_len
                                                               : i_cfg.short_frame_len);
                            n_pos   = 8'(dfpd_pkg::HEADER_BYTES + 1);
                            n_tail  = 1'b0;
                            n_phase = PH_BODY;
                            o_push.cmd.out_valid  = 1'b1;
                            o_push.cmd.out_byte   = b;
                            o_push.cmd.byte_index = 8'(dfpd_pkg::HEADER_BYTES);
                        end else begin
                            n_phase = PH_HUNT;
                            n_len   = '0;
                            n_pos   = '0;
                            n_tc    = '0;
                            n_tail  = 1'b0;
                            o_push.cmd.frame_status = dfpd_pkg::ST_TYPE_ERR;
                        end
                    end
                    PH_BODY: begin
                        if (pos9 == r_len - 9'd2) begin
                            tail_n = (b == i_cfg.tail_dle_value);
                        end
                        o_push.push           = 1'b1;
                        o_push.cmd.out_valid  = 1'b1;
                        o_push.cmd.out_byte   = b;
                        o_push.cmd.byte_index = r_pos;
                        if (pos9 >= r_len - 9'd1) begin
                            good    = tail_n & (b == i_cfg.tail_eof_value);
                            n_phase = PH_HUNT;
                            n_len   = '0;
                            n_pos   = '0;
                            n_tc    = '0;
                            n_tail  = 1'b0;
                            o_push.cmd.frame_status = good ? dfpd_pkg::ST_GOOD
                                                           : dfpd_pkg::ST_BAD_TAIL;
                        end else begin
                            n_tail = tail_n;
                            n_pos  = r_pos + 8'd1;
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_pos   <= '0;
            r_tc    <= '0;
            r_tail  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_tc    <= n_tc;
            r_tail  <= n_tail;
        end
    end

endmodule

### rtl/core/dfpd_queue.sv
// Short command queue that decouples the front and back halves.
module dfpd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dfpd_pkg::t_push     i_push,
    input  logic                i_pop,
    output dfpd_pkg::t_q_status o_status
);

    dfpd_pkg::t_cmd r_mem [dfpd_pkg::Q_DEPTH];

    logic [dfpd_pkg::Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [dfpd_pkg::Q_AW:0]   r_count, n_count;
    logic                      do_push, do_pop;

    assign o_status.full  = (r_count == (dfpd_pkg::Q_AW+1)'(dfpd_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.head  = r_mem[r_rd_ptr];

    assign do_push = i_push.push & ~o_status.full;
    assign do_pop  = i_pop & ~o_status.empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (dfpd_pkg::Q_AW+1)'(dfpd_pkg::Q_DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.push && o_status.full))
        else $error("command pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("command popped from an empty queue");

endmodule

### rtl/core/dfpd_back.sv
// Back half: turns queued commands into result items through an output register.
module dfpd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dfpd_pkg::t_cfg      i_cfg,
    input  dfpd_pkg::t_q_status i_q,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dfpd_pkg::t_out_item o_out_item
);

    logic                r_valid, n_valid;
    logic                r_phase, n_phase;
    dfpd_pkg::t_out_item r_item, n_item;
    logic                load;

    assign load = ~r_valid | ~i_out_stall;

    always_comb begin
        n_valid = r_valid;
        n_phase = r_phase;
        n_item  = r_item;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = ~i_q.empty;
            if (!i_q.empty) begin
                if (i_q.head.hdr && !r_phase) begin
                    // First half of a header: the head escape at position 0.
                    n_phase = 1'b1;
                    n_item  = '{out_valid: 1'b1, out_byte: i_cfg.head_dle_value,
                                byte_index: 8'd0, frame_status: dfpd_pkg::ST_OPEN,
                                last_of_run: 1'b0};
                end else if (i_q.head.hdr) begin
                    n_phase = 1'b0;
                    o_pop   = 1'b1;
                    n_item  = '{out_valid: 1'b1, out_byte: i_q.head.out_byte,
                                byte_index: 8'd1, frame_status: dfpd_pkg::ST_OPEN,
                                last_of_run: 1'b1};
                end else begin
                    o_pop  = 1'b1;
                    n_item = '{out_valid: i_q.head.out_valid, out_byte: i_q.head.out_byte,
                               byte_index: i_q.head.byte_index,
                               frame_status: i_q.head.frame_status, last_of_run: 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    a_hdr_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_item.last_of_run |-> r_item.byte_index == 8'd0
            && r_item.out_byte == i_cfg.head_dle_value && r_phase)
        else $error("non-final result is not the head escape");

    a_hdr_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> !i_q.empty && i_q.head.hdr)
        else $error("header half emitted without its command at the queue head");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_item.frame_status != dfpd_pkg::ST_OPEN |-> r_item.last_of_run)
        else $error("closing status on a non-final result");

endmodule

### rtl/core/dle_framed_packet_deframer.sv
// Top level of the DLE-framed packet deframer: configuration registers and wiring.
// Path: an accepted item is written into the command queue, and its first result is then loaded
// from the queue head into the output register; the second result of a header item follows it.
// Throughput: one item per cycle while the command queue is not full; a header item gives two
// results, absorbed by the four-entry command queue between the front and back halves.
// Reset: synchronous, active low; returns the parser to hunting, empties the queue and
// loads the configuration registers with their documented defaults.
module dle_framed_packet_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dfpd_pkg::PADDR_W-1:0]   paddr,
    input  logic [dfpd_pkg::PDATA_W-1:0]   pwdata,
    output logic [dfpd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  dfpd_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output dfpd_pkg::t_out_item            o_out_item
);

    dfpd_pkg::t_cfg      r_cfg;
    dfpd_pkg::t_push     push;
    dfpd_pkg::t_q_status q_status;
    logic                pop;
    logic                wr_en;
    logic [2:0]          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_dle_value  <= 8'd16;
            r_cfg.head_som_value  <= 8'd2;
            r_cfg.tail_dle_value  <= 8'd16;
            r_cfg.tail_eof_value  <= 8'd3;
            r_cfg.long_frame_len  <= 9'd256;
            r_cfg.short_frame_len <= 9'd16;
            r_cfg.timeout_ticks   <= 8'd4;
        end else if (wr_en) begin
            unique case (reg_idx)
                dfpd_pkg::REG_HEAD_DLE:  r_cfg.head_dle_value  <= pwdata[7:0];
                dfpd_pkg::REG_HEAD_SOM:  r_cfg.head_som_value  <= pwdata[7:0];
                dfpd_pkg::REG_TAIL_DLE:  r_cfg.tail_dle_value  <= pwdata[7:0];
                dfpd_pkg::REG_TAIL_EOF:  r_cfg.tail_eof_value  <= pwdata[7:0];
                dfpd_pkg::REG_LONG_LEN:  r_cfg.long_frame_len  <= pwdata[8:0];
                dfpd_pkg::REG_SHORT_LEN: r_cfg.short_frame_len <= pwdata[8:0];
                dfpd_pkg::REG_TIMEOUT:   r_cfg.timeout_ticks   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dfpd_pkg::REG_HEAD_DLE:  prdata = {24'd0, r_cfg.head_dle_value};
            dfpd_pkg::REG_HEAD_SOM:  prdata = {24'd0, r_cfg.head_som_value};
            dfpd_pkg::REG_TAIL_DLE:  prdata = {24'd0, r_cfg.tail_dle_value};
            dfpd_pkg::REG_TAIL_EOF:  prdata = {24'd0, r_cfg.tail_eof_value};
            dfpd_pkg::REG_LONG_LEN:  prdata = {23'd0, r_cfg.long_frame_len};
            dfpd_pkg::REG_SHORT_LEN: prdata = {23'd0, r_cfg.short_frame_len};
            dfpd_pkg::REG_TIMEOUT:   prdata = {24'd0, r_cfg.timeout_ticks};
            default:                 prdata = '0;
        endcase
    end

    assign o_in_stall = q_status.full;

    dfpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_status.full),
        .o_push     (push)
    );

    dfpd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_status (q_status)
    );

    dfpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q         (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

### tb/dfpd_checker.sv
`timescale 1ns / 100ps
// Deframer checker: follows register writes, predicts results per accepted item and compares.
module dfpd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [dfpd_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [dfpd_pkg::PDATA_W-1:0]  i_pwdata,
    input  logic                          i_pready,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  dfpd_pkg::t_in_item            i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  dfpd_pkg::t_out_item           i_out_item,
    output int                            o_pending,
    output int                            o_fail_count
);

    typedef enum logic [1:0] {HUNTING, AWAIT_SOM, AWAIT_TYPE, IN_FRAME} t_parse;

    dfpd_pkg::t_cfg      cfg;
    t_parse              parse;
    logic [8:0]          frame_len;
    logic [7:0]          next_pos;
    logic [7:0]          ticks;
    logic                tail_ok;
    dfpd_pkg::t_out_item expected_out [$];
    int                  fail_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic queue_result(input logic v, input logic [7:0] b, input logic [7:0] idx,
                                input logic [2:0] status, input logic last);
        dfpd_pkg::t_out_item r;
        r.out_valid    = v;
        r.out_byte     = b;
        r.byte_index   = idx;
        r.frame_status = status;
        r.last_of_run  = last;
        expected_out.push_back(r);
    endtask

    task automatic restart_hunt();
        parse     = HUNTING;
        frame_len = '0;
        next_pos  = '0;
        ticks     = '0;
        tail_ok   = 1'b0;
    endtask

    task automatic write_register(input logic [2:0] idx,
                                  input logic [dfpd_pkg::PDATA_W-1:0] data);
        case (idx)
            dfpd_pkg::REG_HEAD_DLE:  cfg.head_dle_value  = data[7:0];
            dfpd_pkg::REG_HEAD_SOM:  cfg.head_som_value  = data[7:0];
            dfpd_pkg::REG_TAIL_DLE:  cfg.tail_dle_value  = data[7:0];
            dfpd_pkg::REG_TAIL_EOF:  cfg.tail_eof_value  = data[7:0];
            dfpd_pkg::REG_LONG_LEN:  cfg.long_frame_len  = data[8:0];
            dfpd_pkg::REG_SHORT_LEN: cfg.short_frame_len = data[8:0];
            dfpd_pkg::REG_TIMEOUT:   cfg.timeout_ticks   = data[7:0];
            default: ;
        endcase
    endtask

    task automatic deframe_item(input dfpd_pkg::t_in_item it);
        logic [7:0] b;
        logic [8:0] len;
        logic [2:0] status;
        int         pos;
        b = it.rx_byte;
        if (it.req_type) begin
            // Ticks only matter while a frame is open; the count saturates.
            if (parse == AWAIT_TYPE || parse == IN_FRAME) begin
                if (ticks != 8'hFF) ticks = ticks + 8'd1;
                if (ticks >= cfg.timeout_ticks) begin
                    restart_hunt();
                    queue_result(1'b0, 8'd0, 8'd0, dfpd_pkg::ST_TIMEOUT, 1'b1);
                end
            end
        end else begin
            case (parse)
                HUNTING: begin
                    if (b == cfg.head_dle_value) parse = AWAIT_SOM;
                end
                AWAIT_SOM: begin
                    if (b == cfg.head_som_value) begin
                        parse = AWAIT_TYPE;
                        ticks = '0;
                        queue_result(1'b1, cfg.head_dle_value, 8'd0, dfpd_pkg::ST_OPEN, 1'b0);
                        queue_result(1'b1, cfg.head_som_value, 8'd1, dfpd_pkg::ST_OPEN, 1'b1);
                    end else begin
                        parse = HUNTING;
                    end
                end
                AWAIT_TYPE: begin
                    if (b > 0 && b < dfpd_pkg::TYPE_LIMIT) begin
                        len = b[0] ? cfg.long_frame_len : cfg.short_frame_len;
                        if (len < dfpd_pkg::MIN_FRAME_BYTES) begin
                            len = 9'(dfpd_pkg::MIN_FRAME_BYTES);
                        end else if (len > dfpd_pkg::MAX_FRAME_BYTES) begin
                            len = 9'(dfpd_pkg::MAX_FRAME_BYTES);
                        end
                        frame_len = len;
                        next_pos  = 8'(dfpd_pkg::HEADER_BYTES + 1);
                        tail_ok   = 1'b0;
                        parse     = IN_FRAME;
                        queue_result(1'b1, b, 8'(dfpd_pkg::HEADER_BYTES),
                                     dfpd_pkg::ST_OPEN, 1'b1);
                    end else begin
                        restart_hunt();
                        queue_result(1'b0, 8'd0, 8'd0, dfpd_pkg::ST_TYPE_ERR, 1'b1);
                    end
                end
                default: begin
                    pos = next_pos;
                    if (pos == frame_len - 2) tail_ok = (b == cfg.tail_dle_value);
                    if (pos >= frame_len - 1) begin
                        status = (tail_ok && b == cfg.tail_eof_value) ? dfpd_pkg::ST_GOOD
                                                                      : dfpd_pkg::ST_BAD_TAIL;
                        restart_hunt();
                        queue_result(1'b1, b, 8'(pos), status, 1'b1);
                    end else begin
                        next_pos = 8'(pos + 1);
                        queue_result(1'b1, b, 8'(pos), dfpd_pkg::ST_OPEN, 1'b1);
                    end
                end
            endcase
        end
    endtask

    task automatic check_result(input dfpd_pkg::t_out_item got);
        dfpd_pkg::t_out_item want;
        if (expected_out.size() == 0) begin
            report_mismatch("result with nothing expected", 32'(got), 32'd0);
        end else begin
            want = expected_out.pop_front();
            if (got.out_valid !== want.out_valid)
                report_mismatch("out_valid", 32'(got.out_valid), 32'(want.out_valid));
            if (got.out_byte !== want.out_byte)
                report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
            if (got.byte_index !== want.byte_index)
                report_mismatch("byte_index", 32'(got.byte_index), 32'(want.byte_index));
            if (got.frame_status !== want.frame_status)
                report_mismatch("frame_status", 32'(got.frame_status),
                                32'(want.frame_status));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.head_dle_value  = 8'd16;
            cfg.head_som_value  = 8'd2;
            cfg.tail_dle_value  = 8'd16;
            cfg.tail_eof_value  = 8'd3;
            cfg.long_frame_len  = 9'd256;
            cfg.short_frame_len = 9'd16;
            cfg.timeout_ticks   = 8'd4;
            restart_hunt();
            expected_out.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                write_register(i_paddr[dfpd_pkg::PADDR_W-1:2], i_pwdata);
            if (i_in_valid && !i_in_stall) deframe_item(i_in_item);
            if (i_out_valid && !i_out_stall) check_result(i_out_item);
        end
        o_pending    <= expected_out.size();
        o_fail_count <= fail_count;
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Deframer testbench top: clock, reset, register writes, item stimulus, idling and verdict.
module tb_top;

    localparam logic       REQ_BYTE      = 1'b0;
    localparam logic       REQ_TICK      = 1'b1;
    localparam logic [2:0] REG_UNUSED    = 3'd7;
    localparam int         ITEM_TARGET   = 1050;
    localparam int         HOLD_CYCLES   = 80;
    localparam int         IDLE_LIMIT    = 4000;
    localparam int         SETTLE_CYCLES = 4;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         psel        = 1'b0;
    logic                         penable     = 1'b0;
    logic                         pwrite      = 1'b0;
    logic [dfpd_pkg::PADDR_W-1:0] paddr       = '0;
    logic [dfpd_pkg::PDATA_W-1:0] pwdata      = '0;
    logic [dfpd_pkg::PDATA_W-1:0] prdata;
    logic                         pready;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    dfpd_pkg::t_in_item           i_in_item   = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    dfpd_pkg::t_out_item          o_out_item;

    int pending;
    int fail_count;

    // Frame shaping for the current register setting.
    logic [7:0] dle_b, som_b, tail_b, eof_b;
    int         long_n, short_n;
    int         tick_pct    = 0;
    int         items_sent  = 0;
    bit         calm        = 1'b0;
    bit         hold_req    = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    dle_framed_packet_deframer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    dfpd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom());
    endfunction

    function automatic logic [8:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return 9'($urandom_range(5, 12));
        if (r < 16) return 9'($urandom_range(0, 4));
        if (r == 16) return 9'($urandom_range(13, 40));
        if (r == 17) return 9'd256;
        return 9'($urandom_range(257, 511));
    endfunction

    function automatic logic [7:0] pick_timeout();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r < 4) return 8'($urandom_range(1, 3));
        return 8'($urandom_range(100, 255));
    endfunction

    function automatic int eff_len(input logic [8:0] v);
        if (v < dfpd_pkg::MIN_FRAME_BYTES) return dfpd_pkg::MIN_FRAME_BYTES;
        if (v > dfpd_pkg::MAX_FRAME_BYTES) return dfpd_pkg::MAX_FRAME_BYTES;
        return int'(v);
    endfunction

    // Offers one item after an optional gap and returns at the edge that takes it.
    task automatic send_item(input logic kind, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{req_type: kind, rx_byte: b};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // The pending count is registered in the checker, hence the edge before polling it.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [dfpd_pkg::PDATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Upper data bits are random: the registers must keep only their own width.
    task automatic configure(input logic [7:0] dle, input logic [7:0] som,
                             input logic [7:0] tail, input logic [7:0] eof,
                             input logic [8:0] long_v, input logic [8:0] short_v,
                             input logic [7:0] tmo);
        reg_write(dfpd_pkg::REG_HEAD_DLE,  {24'($urandom()), dle});
        reg_write(dfpd_pkg::REG_HEAD_SOM,  {24'($urandom()), som});
        reg_write(dfpd_pkg::REG_TAIL_DLE,  {24'($urandom()), tail});
        reg_write(dfpd_pkg::REG_TAIL_EOF,  {24'($urandom()), eof});
        reg_write(dfpd_pkg::REG_LONG_LEN,  {23'($urandom()), long_v});
        reg_write(dfpd_pkg::REG_SHORT_LEN, {23'($urandom()), short_v});
        reg_write(dfpd_pkg::REG_TIMEOUT,   {24'($urandom()), tmo});
        if ($urandom_range(0, 3) == 0) reg_write(REG_UNUSED, $urandom());
        dle_b   = dle;
        som_b   = som;
        tail_b  = tail;
        eof_b   = eof;
        long_n  = eff_len(long_v);
        short_n = eff_len(short_v);
    endtask

    task automatic maybe_tick();
        if ($urandom_range(0, 99) < tick_pct) begin
            send_item(REQ_TICK, 8'($urandom()));
            items_sent++;
        end
    endtask

    // Mostly well-formed frames with random content; some are broken on purpose.
    task automatic send_frame();
        int         len, cut, pos;
        logic [7:0] kind_b, b;
        if (items_sent >= ITEM_TARGET) return;
        repeat ($urandom_range(0, 2)) begin
            send_item(REQ_BYTE, 8'($urandom()));
            items_sent++;
        end
        if ($urandom_range(0, 9) == 0) begin
            send_item(REQ_TICK, 8'($urandom()));
            items_sent++;
        end
        send_item(REQ_BYTE, dle_b);
        items_sent++;
        if ($urandom_range(0, 9) == 0) begin
            send_item(REQ_BYTE, 8'($urandom()));
            items_sent++;
            return;
        end
        send_item(REQ_BYTE, som_b);
        items_sent++;
        maybe_tick();
        kind_b = ($urandom_range(0, 6) == 0) ? 8'($urandom()) : 8'($urandom_range(1, 6));
        send_item(REQ_BYTE, kind_b);
        items_sent++;
        if (kind_b == 0 || kind_b >= dfpd_pkg::TYPE_LIMIT) return;
        len = kind_b[0] ? long_n : short_n;
        cut = ($urandom_range(0, 11) == 0) ? $urandom_range(3, len - 1) : len;
        for (pos = 3; pos < cut && items_sent < ITEM_TARGET; pos++) begin
            maybe_tick();
            if (pos == len - 2 && $urandom_range(0, 6) != 0) begin
                b = tail_b;
            end else if (pos == len - 1 && $urandom_range(0, 6) != 0) begin
                b = eof_b;
            end else begin
                b = 8'($urandom());
            end
            send_item(REQ_BYTE, b);
            items_sent++;
        end
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on request.
    initial begin
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = $urandom_range(0, 9);
                n = (n < 5) ? 0 : (n < 9) ? $urandom_range(1, 3) : $urandom_range(15, 40);
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    initial begin
        int idle;
        idle = 0;
        while (!i_rst_n) @(posedge i_clk);
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [8:0] opening [26];
        int         phase, frames, longest;
        // Defaults first, then a small setting: bad start byte equal to the escape,
        // type errors at both ends, a good and a bad tail, and a timeout.
        opening = '{{REQ_BYTE, 8'h00}, {REQ_TICK, 8'hFF}, {REQ_BYTE, 8'h10}, {REQ_BYTE, 8'h10},
                    {REQ_BYTE, 8'h10}, {REQ_BYTE, 8'h02}, {REQ_BYTE, 8'h00},
                    {REQ_BYTE, 8'h10}, {REQ_BYTE, 8'h02}, {REQ_BYTE, 8'hFF},
                    {REQ_BYTE, 8'h10}, {REQ_BYTE, 8'h02}, {REQ_BYTE, 8'h02},
                    {REQ_BYTE, 8'h10}, {REQ_BYTE, 8'h03},
                    {REQ_BYTE, 8'h10}, {REQ_BYTE, 8'h02}, {REQ_BYTE, 8'h01},
                    {REQ_BYTE, 8'h00}, {REQ_BYTE, 8'hFF}, {REQ_BYTE, 8'h03},
                    {REQ_BYTE, 8'h10}, {REQ_BYTE, 8'h02}, {REQ_BYTE, 8'h04},
                    {REQ_TICK, 8'h00}, {REQ_TICK, 8'hAA}};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 26; i++) begin
            if (i == 7) begin
                drain();
                configure(8'h10, 8'h02, 8'h10, 8'h03, 9'd6, 9'd5, 8'd2);
            end
            send_item(opening[i][8], opening[i][7:0]);
            items_sent++;
        end
        drain();

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0: configure(8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 9'd5, 8'd0);
                1: configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'd511, 9'd256, 8'd255);
                default: configure(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                                   pick_len(), pick_len(), pick_timeout());
            endcase
            calm     = (phase > 2) && ($urandom_range(0, 4) == 0);
            tick_pct = $urandom_range(0, 8);
            longest  = (long_n > short_n) ? long_n : short_n;
            frames   = 150 / longest;
            if (frames < 2) frames = 2;
            // In the third setting the receiver holds off while items keep coming.
            if (phase == 2) hold_req = 1'b1;
            repeat (frames) send_frame();
            drain();
            phase++;
        end
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
